FILE: rtl/core/mtb_pkg.sv
package mtb_pkg;

  localparam int ID_W = 8;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_TOUCH = 2'd1,
    FUNC_DUMP  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_t;

  // Command broadcast to every cell in the chain
  typedef struct packed {
    logic load;   // cell at index == count takes the insert value
    logic move;   // cells at or behind the hit shift toward the front
  } cell_cmd_t;

  typedef logic [ID_W-1:0] ident_t;

endpackage

FILE: rtl/core/mtb_if.sv
interface mtb_in_if;
  logic              valid;
  logic              ready;
  mtb_pkg::func_t    func;
  mtb_pkg::ident_t   ident;

  modport source (output valid, output func, output ident, input ready);
  modport sink   (input valid, input func, input ident, output ready);
endinterface

interface mtb_out_if;
  logic              valid;
  logic              ready;
  mtb_pkg::ident_t   ident_out;
  mtb_pkg::status_t  status;
  logic              last;

  modport source (output valid, output ident_out, output status, output last, input ready);
  modport sink   (input valid, input ident_out, input status, input last, output ready);
endinterface

FILE: rtl/core/move_to_back_order_list.sv
// Ordered list of up to ENTRIES distinct 8-bit identifiers, front = least
// recently used. Load appends at the back, touch moves a present identifier
// to the back, clear empties the list, dump streams the list front to back
// with last set on the final entry (an empty list gives one result with
// status empty). Load, touch and clear each give one result: every cell
// compares and shifts in parallel. A dump of N entries holds the input
// while the chain rotates one entry per cycle out of the front cell when
// the output is not stalled; an output stall holds the rotation. The output
// is a single register: a new item is taken only in a cycle where no result
// is held or the held result leaves.
module move_to_back_order_list #(
  parameter int ENTRIES = 16
) (
  input  logic clk,
  input  logic rst_n,
  mtb_in_if.sink    in_ch,
  mtb_out_if.source out_ch
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_C = CNT_W'(ENTRIES);
  localparam logic [CNT_W-1:0] ONE_C  = CNT_W'(1);

  mtb_pkg::state_t    state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic               out_valid_r, out_valid_nxt;
  mtb_pkg::ident_t    out_ident_r, out_ident_nxt;
  mtb_pkg::status_t   out_status_r, out_status_nxt;
  logic               out_last_r, out_last_nxt;

  mtb_pkg::cell_cmd_t cmd;
  mtb_pkg::ident_t    ins_data;
  logic               rotate;
  logic               slot_free;
  logic               acc;

  mtb_pkg::ident_t    data_w [ENTRIES];
  logic [ENTRIES:0]   hit_w;
  logic               found;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == mtb_pkg::S_IDLE) && slot_free;
  assign acc = in_ch.valid && in_ch.ready;

  // A dump rotation is a move whose hit starts at the front cell
  assign hit_w[0] = rotate;
  assign found    = hit_w[ENTRIES];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    mtb_pkg::ident_t right;
    if (i == ENTRIES - 1) begin : g_end
      assign right = '0;
    end else begin : g_mid
      assign right = data_w[i+1];
    end
    mtb_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count_r),
      .key        (in_ch.ident),
      .ins_data   (ins_data),
      .right_data (right),
      .hit_in     (hit_w[i]),
      .hit_out    (hit_w[i+1]),
      .data_o     (data_w[i])
    );
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mtb_pkg::S_IDLE: begin
        if (acc && (in_ch.func == mtb_pkg::FUNC_DUMP) && (count_r != '0)) begin
          state_nxt = mtb_pkg::S_DUMP;
        end
      end
      mtb_pkg::S_DUMP: begin
        if (slot_free && (rem_r == ONE_C)) begin
          state_nxt = mtb_pkg::S_IDLE;
        end
      end
      default: state_nxt = mtb_pkg::S_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    cmd            = '0;
    ins_data       = in_ch.ident;
    rotate         = 1'b0;
    count_nxt      = count_r;
    rem_nxt        = rem_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_ident_nxt  = out_ident_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      mtb_pkg::S_IDLE: begin
        if (acc) begin
          out_valid_nxt  = 1'b1;
          out_ident_nxt  = in_ch.ident;
          out_status_nxt = mtb_pkg::ST_OK;
          out_last_nxt   = 1'b1;
          case (in_ch.func)
            mtb_pkg::FUNC_LOAD: begin
              if (found) begin
                out_status_nxt = mtb_pkg::ST_DUPLICATE;
              end else if (count_r == FULL_C) begin
                out_status_nxt = mtb_pkg::ST_FULL;
              end else begin
                cmd.load  = 1'b1;
                count_nxt = count_r + ONE_C;
              end
            end
            mtb_pkg::FUNC_TOUCH: begin
              if (found) begin
                cmd.move = 1'b1;
              end else begin
                out_status_nxt = mtb_pkg::ST_NOT_FOUND;
              end
            end
            mtb_pkg::FUNC_DUMP: begin
              out_ident_nxt = '0;
              if (count_r == '0) begin
                out_status_nxt = mtb_pkg::ST_EMPTY;
              end else begin
                out_valid_nxt = out_valid_r && !out_ch.ready;
                rem_nxt       = count_r;
              end
            end
            mtb_pkg::FUNC_CLEAR: begin
              out_ident_nxt = '0;
              count_nxt     = '0;
            end
            default: ;
          endcase
        end
      end
      mtb_pkg::S_DUMP: begin
        if (slot_free) begin
          rotate         = 1'b1;
          cmd.move       = 1'b1;
          ins_data       = data_w[0];
          out_valid_nxt  = 1'b1;
          out_ident_nxt  = data_w[0];
          out_status_nxt = mtb_pkg::ST_OK;
          out_last_nxt   = (rem_r == ONE_C);
          rem_nxt        = rem_r - ONE_C;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mtb_pkg::S_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ident_r  <= out_ident_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.ident_out = out_ident_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.last      = out_last_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_C)
    else $error("fill count above capacity");

  a_dump_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mtb_pkg::S_DUMP) |-> (rem_r != '0))
    else $error("dump running with nothing left");

  a_no_accept_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mtb_pkg::S_DUMP) |-> !in_ch.ready)
    else $error("input taken during dump");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_ch.func == mtb_pkg::FUNC_CLEAR)) |=> (count_r == '0))
    else $error("clear left entries");

  a_dump_count_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mtb_pkg::S_DUMP) |=> $stable(count_r))
    else $error("fill count changed during dump");

endmodule

FILE: rtl/core/mtb_cell.sv
module mtb_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic               clk,
  input  mtb_pkg::cell_cmd_t cmd,
  input  logic [CNT_W-1:0]   count,
  input  mtb_pkg::ident_t    key,
  input  mtb_pkg::ident_t    ins_data,
  input  mtb_pkg::ident_t    right_data,
  input  logic               hit_in,
  output logic               hit_out,
  output mtb_pkg::ident_t    data_o
);

  localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] IDX1_C = CNT_W'(IDX + 1);

  mtb_pkg::ident_t data_r;
  mtb_pkg::ident_t data_nxt;
  logic            occ;
  logic            hit_here;

  assign occ      = (IDX_C < count);
  assign hit_here = hit_in | (occ && (data_r == key));
  assign hit_out  = hit_here;
  assign data_o   = data_r;

  always_comb begin
    data_nxt = data_r;
    if (cmd.load && (IDX_C == count)) begin
      data_nxt = ins_data;
    end else if (cmd.move && hit_here) begin
      if (IDX1_C < count) begin
        data_nxt = right_data;
      end else if (IDX1_C == count) begin
        data_nxt = ins_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule
